FILE: rtl/core/crng_pkg.sv
// ---------------------------------------------------------------------------
// crng_pkg: shared constants for the combined LCG shuffle generator
// Moduli, multipliers, fold constants, generator select codes and the
// reset and saturation values used across the design files.
// ---------------------------------------------------------------------------
package crng_pkg;

   // Word widths
   localparam int VAL_W  = 31;
   localparam int FRAC_W = 32;
   localparam int MUL_W  = 16;
   localparam int FOLD_W = 8;

   // Generator moduli and multipliers
   localparam logic [VAL_W-1:0] MOD1 = 31'd2147483563;
   localparam logic [VAL_W-1:0] MOD2 = 31'd2147483399;
   localparam logic [MUL_W-1:0] MUL1 = 16'd40014;
   localparam logic [MUL_W-1:0] MUL2 = 16'd40692;

   // 2^31 mod MODx, used to fold the high part of a product back in
   localparam logic [FOLD_W-1:0] FOLD1 = 8'd85;
   localparam logic [FOLD_W-1:0] FOLD2 = 8'd249;

   // Largest deviate and saturation point of the fraction
   localparam logic [VAL_W-1:0]  LAST_MAX = 31'd2147483562;
   localparam logic [FRAC_W-1:0] FRAC_MAX = 32'd4294966780;

   // Sequencing
   localparam int WARMUP_STEPS        = 8;
   localparam int DEFAULT_TABLE_DEPTH = 32;

   // Reset value of the seed register
   localparam logic [VAL_W-1:0] SEED_RESET = 31'd50;

   // Generator select codes for the shared modular multiplier
   localparam logic GEN_FIRST  = 1'b0;
   localparam logic GEN_SECOND = 1'b1;

endpackage

FILE: rtl/core/crng_modmul.sv
// ---------------------------------------------------------------------------
// crng_modmul: pipelined modular multiplier for both generators
// Computes (MULx * x) mod MODx. A new operand may enter every cycle; the
// result passes the product and fold registers, then the subtract.
// ---------------------------------------------------------------------------
module crng_modmul (
   input  logic                        clock,
   input  logic                        op_sel,
   input  logic [crng_pkg::VAL_W-1:0]  op_x,
   output logic [crng_pkg::VAL_W-1:0]  res
);

   localparam int PROD_W = crng_pkg::VAL_W + crng_pkg::MUL_W;
   localparam int HI_W   = PROD_W - crng_pkg::VAL_W;
   localparam int SUM_W  = crng_pkg::VAL_W + 1;

   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic                       sel1_ff, sel2_ff;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic [crng_pkg::MUL_W-1:0] mul;
   logic [crng_pkg::FOLD_W-1:0] fold;
   logic [HI_W-1:0]            hi;
   logic [crng_pkg::VAL_W-1:0] modulus;

   // Stage 1: multiply by the generator's multiplier
   always_comb begin
      mul     = (op_sel == crng_pkg::GEN_SECOND) ? crng_pkg::MUL2 : crng_pkg::MUL1;
      prod_in = PROD_W'(op_x) * PROD_W'(mul);
   end

   // Stage 2: fold high bits back, 2^31 == FOLDx (mod MODx)
   always_comb begin
      fold   = (sel1_ff == crng_pkg::GEN_SECOND) ? crng_pkg::FOLD2 : crng_pkg::FOLD1;
      hi     = prod_ff[PROD_W-1:crng_pkg::VAL_W];
      sum_in = SUM_W'(prod_ff[crng_pkg::VAL_W-1:0]) + SUM_W'(hi) * SUM_W'(fold);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sel1_ff <= op_sel;
      sum_ff  <= sum_in;
      sel2_ff <= sel1_ff;
   end

   // Stage 3: folded sum is below twice the modulus, one subtract finishes
   always_comb begin
      modulus = (sel2_ff == crng_pkg::GEN_SECOND) ? crng_pkg::MOD2 : crng_pkg::MOD1;
      if (sum_ff >= SUM_W'(modulus)) begin
         res = crng_pkg::VAL_W'(sum_ff - SUM_W'(modulus));
      end else begin
         res = sum_ff[crng_pkg::VAL_W-1:0];
      end
   end

endmodule

FILE: rtl/core/crng_table.sv
// ---------------------------------------------------------------------------
// crng_table: shuffle table memory
// One write port and one read port; read data is registered and holds
// until the next read.
// ---------------------------------------------------------------------------
module crng_table #(
   parameter int TABLE_DEPTH = crng_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
   input  logic [crng_pkg::VAL_W-1:0]     wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
   output logic [crng_pkg::VAL_W-1:0]     rd_data
);

   logic [crng_pkg::VAL_W-1:0] mem [TABLE_DEPTH];
   logic [crng_pkg::VAL_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/crng_frac.sv
// ---------------------------------------------------------------------------
// crng_frac: Q0.32 scaling of the deviate
// floor(L * 2^32 / MOD1) by reciprocal estimate 2L + (170L >> 31) with a
// single +1 correction, then saturation at FRAC_MAX.
// One register stage; output is valid in the cycle after the input settles.
// ---------------------------------------------------------------------------
module crng_frac (
   input  logic                         clock,
   input  logic [crng_pkg::VAL_W-1:0]   value,
   output logic [crng_pkg::FRAC_W-1:0]  frac
);

   localparam int SCALE_W = crng_pkg::VAL_W + crng_pkg::FOLD_W;
   localparam int EST_W   = crng_pkg::FRAC_W + 1;
   localparam int REM_W   = crng_pkg::VAL_W + 1;

   logic [SCALE_W-1:0]          scaled_ff, scaled_in;
   logic [crng_pkg::VAL_W-1:0]  value_ff;
   logic [crng_pkg::FOLD_W-1:0] carry;
   logic [REM_W-1:0]            rem;
   logic [EST_W-1:0]            est;
   logic [EST_W-1:0]            quot;

   // 170 * L, where 170 = 2 * (2^31 - MOD1)
   assign scaled_in = SCALE_W'(value) * SCALE_W'({crng_pkg::FOLD1, 1'b0});

   always_ff @(posedge clock) begin
      scaled_ff <= scaled_in;
      value_ff  <= value;
   end

   // Estimate, exact remainder, correction and clamp
   always_comb begin
      carry = scaled_ff[SCALE_W-1:crng_pkg::VAL_W];
      rem   = REM_W'(scaled_ff[crng_pkg::VAL_W-1:0])
            + REM_W'(carry) * REM_W'(crng_pkg::FOLD1);
      est   = EST_W'({value_ff, 1'b0}) + EST_W'(carry);
      quot  = (rem >= REM_W'(crng_pkg::MOD1)) ? est + EST_W'(1) : est;
      if (quot > EST_W'(crng_pkg::FRAC_MAX)) begin
         frac = crng_pkg::FRAC_MAX;
      end else begin
         frac = quot[crng_pkg::FRAC_W-1:0];
      end
   end

endmodule

FILE: rtl/core/combined_lcg_shuffle_rng_top.sv
// ---------------------------------------------------------------------------
// combined_lcg_shuffle_rng_top: combined LCG generator with shuffle table
// Two multiplicative LCGs share one modular multiplier; their outputs are
// combined through a Bays-Durham shuffle table held in a synchronous RAM.
//
//   channel  direction  handshake            payload
//   req      in         req_tvalid/tready    req_tdata[0] restart
//   rsp      out        rsp_tvalid/tready    rsp_tdata[30:0] random_integer,
//                                            rsp_tdata[62:31] random_fraction
//   csr      in         csr_valid/ready      csr_wdata seed_magnitude
//
// A draw steps through DRAW_A to DRAW_D, SLOT_A, SLOT_B and EMIT; the result
// sits in the rsp register and the next draw starts while it waits.
// An initialization (first draw after reset or restart set) adds 40 dependent
// generator steps by default (WARMUP_STEPS + TABLE_DEPTH), each INIT_ISS, INIT_WAIT,
// INIT_DONE through the modular multiplier, then SLOT_A and SLOT_B to form the
// first table index. Reset clears control and the seed register only; the table
// holds nothing valid until the first initialization, which always runs first.
// A full rsp register stalls the sequencer in its last step.
// ---------------------------------------------------------------------------
module combined_lcg_shuffle_rng_top #(
   parameter int TABLE_DEPTH = crng_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   // req_tdata: [0] restart, [7:1] zero
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,
   // rsp_tdata: [30:0] random_integer, [62:31] random_fraction, [63] zero
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [63:0]                 rsp_tdata,
   // seed_magnitude write
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [crng_pkg::VAL_W-1:0]  csr_wdata
);

   localparam int VAL_W = crng_pkg::VAL_W;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int QW    = IDX_W + 1;

   // Table index divisor and its reciprocal estimate
   localparam logic [VAL_W-1:0] NDIV = VAL_W'(1 + crng_pkg::LAST_MAX / TABLE_DEPTH);
   localparam logic [32:0] RECIP_FULL = 33'h1_0000_0000 / {2'b00, NDIV};
   localparam int RECIP_W = $clog2(int'(RECIP_FULL) + 1);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
   localparam int EPROD_W = VAL_W + RECIP_W;
   localparam int BPROD_W = VAL_W + QW;

   // Initialization step count
   localparam int INIT_STEPS = crng_pkg::WARMUP_STEPS + TABLE_DEPTH;
   localparam int CNT_W      = $clog2(INIT_STEPS);

   // Sequencer states
   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_INIT_ISS  = 4'd1;
   localparam logic [3:0] ST_INIT_WAIT = 4'd2;
   localparam logic [3:0] ST_INIT_DONE = 4'd3;
   localparam logic [3:0] ST_DRAW_A    = 4'd4;
   localparam logic [3:0] ST_DRAW_B    = 4'd5;
   localparam logic [3:0] ST_DRAW_C    = 4'd6;
   localparam logic [3:0] ST_DRAW_D    = 4'd7;
   localparam logic [3:0] ST_SLOT_A    = 4'd8;
   localparam logic [3:0] ST_SLOT_B    = 4'd9;
   localparam logic [3:0] ST_EMIT      = 4'd10;

   logic [3:0]       state_ff, state_in;
   logic             primed_ff, primed_in;
   logic             init_flow_ff, init_flow_in;
   logic [VAL_W-1:0] seed_ff;
   logic [VAL_W-1:0] gen1_ff, gen1_in;
   logic [VAL_W-1:0] gen2_ff, gen2_in;
   logic [VAL_W-1:0] last_ff, last_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [QW-1:0]    est_ff, est_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_int_ff;
   logic [crng_pkg::FRAC_W-1:0] rsp_frac_ff;

   logic                        op_sel;
   logic [VAL_W-1:0]            op_x;
   logic [VAL_W-1:0]            mm_res;
   logic                        wr_en, rd_en;
   logic [IDX_W-1:0]            wr_addr;
   logic [VAL_W-1:0]            rd_data;
   logic [crng_pkg::FRAC_W-1:0] frac;
   logic                        req_xfer, out_free, load_rsp;
   logic [VAL_W-1:0]            seed_eff;
   logic [IDX_W-1:0]            fill_addr;
   logic                        fill_step, last_step;
   logic signed [VAL_W+1:0]     diff;
   logic [EPROD_W-1:0]          est_prod;
   logic [BPROD_W-1:0]          back_prod, rem;
   logic [QW-1:0]               quot;

   // Configuration register, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= crng_pkg::SEED_RESET;
      end else if (csr_valid) begin
         seed_ff <= csr_wdata;
      end
   end

   // Shared modular multiplier for both generators
   crng_modmul u_modmul (
      .clock  (clock),
      .op_sel (op_sel),
      .op_x   (op_x),
      .res    (mm_res)
   );

   assign op_sel = (state_ff == ST_DRAW_B) ? crng_pkg::GEN_SECOND : crng_pkg::GEN_FIRST;
   assign op_x   = (state_ff == ST_DRAW_B) ? gen2_ff : gen1_ff;

   // Shuffle table
   crng_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (mm_res),
      .rd_en   (rd_en),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

   // Initialization fills from the top entry down
   assign fill_step = (cnt_ff >= CNT_W'(crng_pkg::WARMUP_STEPS));
   assign last_step = (cnt_ff == CNT_W'(INIT_STEPS - 1));
   assign fill_addr = IDX_W'(CNT_W'(INIT_STEPS - 1) - cnt_ff);

   assign rd_en   = (state_ff == ST_DRAW_A);
   assign wr_en   = (state_ff == ST_DRAW_C) || ((state_ff == ST_INIT_DONE) && fill_step);
   assign wr_addr = (state_ff == ST_DRAW_C) ? slot_ff : fill_addr;

   // Fraction scaling of the current deviate
   crng_frac u_frac (
      .clock (clock),
      .value (last_ff),
      .frac  (frac)
   );

   // Handshake
   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign load_rsp   = (state_ff == ST_EMIT) && out_free;
   assign seed_eff   = (seed_ff == '0) ? VAL_W'(1) : seed_ff;

   // Combine: picked entry minus second generator, wrapped into 1..LAST_MAX
   always_comb begin
      diff = $signed({2'b00, rd_data}) - $signed({2'b00, mm_res});
      if (diff < 1) begin
         diff = diff + $signed({2'b00, crng_pkg::LAST_MAX});
      end
   end

   // Table index: reciprocal estimate, then one correction and a clamp
   assign est_prod  = EPROD_W'(last_ff) * EPROD_W'(RECIP);
   assign est_in    = QW'(est_prod >> 32);
   assign back_prod = BPROD_W'(est_ff) * BPROD_W'(NDIV);
   assign rem       = BPROD_W'(last_ff) - back_prod;
   assign quot      = (rem >= BPROD_W'(NDIV)) ? est_ff + QW'(1) : est_ff;
   assign slot_in   = (quot >= QW'(TABLE_DEPTH)) ? IDX_W'(TABLE_DEPTH - 1) : IDX_W'(quot);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      primed_in    = primed_ff;
      init_flow_in = init_flow_ff;
      gen1_in      = gen1_ff;
      gen2_in      = gen2_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_tdata[0] || !primed_ff) begin
                  gen1_in  = seed_eff;
                  gen2_in  = seed_eff;
                  cnt_in   = '0;
                  state_in = ST_INIT_ISS;
               end else begin
                  state_in = ST_DRAW_A;
               end
            end
         end
         ST_INIT_ISS:  state_in = ST_INIT_WAIT;
         ST_INIT_WAIT: state_in = ST_INIT_DONE;
         ST_INIT_DONE: begin
            gen1_in = mm_res;
            if (last_step) begin
               last_in      = mm_res;
               primed_in    = 1'b1;
               init_flow_in = 1'b1;
               state_in     = ST_SLOT_A;
            end else begin
               cnt_in   = cnt_ff + CNT_W'(1);
               state_in = ST_INIT_ISS;
            end
         end
         ST_DRAW_A: state_in = ST_DRAW_B;
         ST_DRAW_B: state_in = ST_DRAW_C;
         ST_DRAW_C: begin
            gen1_in  = mm_res;
            state_in = ST_DRAW_D;
         end
         ST_DRAW_D: begin
            gen2_in  = mm_res;
            last_in  = VAL_W'(diff);
            state_in = ST_SLOT_A;
         end
         ST_SLOT_A: state_in = ST_SLOT_B;
         ST_SLOT_B: begin
            if (init_flow_ff) begin
               init_flow_in = 1'b0;
               state_in     = ST_DRAW_A;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         primed_ff    <= 1'b0;
         init_flow_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         primed_ff    <= primed_in;
         init_flow_ff <= init_flow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      gen1_ff <= gen1_in;
      gen2_ff <= gen2_in;
      last_ff <= last_in;
      cnt_ff  <= cnt_in;
      if (state_ff == ST_SLOT_A) begin
         est_ff <= est_in;
      end
      if (state_ff == ST_SLOT_B) begin
         slot_ff <= slot_in;
      end
      if (load_rsp) begin
         rsp_int_ff  <= last_ff;
         rsp_frac_ff <= frac;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_frac_ff, rsp_int_ff};

endmodule
